FILE: design/fpdic_pkg.sv
// shared types and constants of the fuzzy pd integrating controller
`timescale 1ns / 1ps

package fpdic_pkg;

  // field widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  localparam int ERR_W  = 24;
  localparam int LIM_W  = 21;
  localparam int KP_W   = 16;
  localparam int KD_W   = 24;
  localparam int KI_W   = 16;
  localparam int DB_W   = 15;

  // datapath widths
  localparam int MAG_W  = IN_W + 1;
  localparam int X_W    = 30;
  localparam int Q_W    = 24;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = LIM_W + 2;

  // scaling constants
  localparam int GAIN_SHIFT  = 8;
  localparam int DRV_SHIFT   = 16;
  localparam int DIV_CONST   = 100;
  localparam int ROUND_HALF  = DIV_CONST / 2;
  localparam int SCALE_OUT   = 100;
  // error saturates once the rounded numerator reaches 100 * 2^23
  localparam int SAT_NUM     = DIV_CONST * (1 << (ERR_W - 1));
  // floor(2^37 / 100), low by at most one quotient step for 30 bit dividends
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_MULT  = 1374389534;

  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // register port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [IDX_W-1:0] REG_KD       = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI       = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEADBAND = 3'd3;
  localparam logic [IDX_W-1:0] REG_POS_LIM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_NEG_LIM  = 3'd5;
  localparam logic [IDX_W-1:0] REG_REVERSE  = 3'd6;

  localparam logic [KP_W-1:0]         KP_RESET      = 16'd256;
  localparam logic signed [LIM_W-1:0] POS_LIM_RESET = 21'sd65536;
  localparam logic signed [LIM_W-1:0] NEG_LIM_RESET = -21'sd65536;

  typedef struct packed {
    logic [KP_W-1:0]         kp;
    logic [KD_W-1:0]         kd_over_period;
    logic [KI_W-1:0]         ki_times_period;
    logic [DB_W-1:0]         deadband;
    logic signed [LIM_W-1:0] pos_int_limit;
    logic signed [LIM_W-1:0] neg_int_limit;
    logic                    reverse_output;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_RECIP, ST_QUOT, ST_CHECK, ST_CORR, ST_KP, ST_KD,
    ST_DTERM, ST_AB, ST_FUZZ, ST_KI, ST_ACC, ST_DRV, ST_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_RECIP, OP_QUOT, OP_CHECK, OP_CORR, OP_KP,
    OP_KD, OP_DTERM, OP_AB, OP_FUZZ, OP_KI, OP_ACC, OP_DRV, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

endpackage

FILE: design/fpdic_cfg_regs.sv
// apb register file holding the controller gains, limits, deadband and output sense
`timescale 1ns / 1ps

module fpdic_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpdic_pkg::PADDR_W-1:0]   paddr,
  input  logic [fpdic_pkg::DATA_W-1:0]    pwdata,
  output logic [fpdic_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  output fpdic_pkg::cfg_t                 cfg
);
  import fpdic_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp              <= KP_RESET;
      cfg.kd_over_period  <= '0;
      cfg.ki_times_period <= '0;
      cfg.deadband        <= '0;
      cfg.pos_int_limit   <= POS_LIM_RESET;
      cfg.neg_int_limit   <= NEG_LIM_RESET;
      cfg.reverse_output  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KP:       cfg.kp              <= pwdata[KP_W-1:0];
        REG_KD:       cfg.kd_over_period  <= pwdata[KD_W-1:0];
        REG_KI:       cfg.ki_times_period <= pwdata[KI_W-1:0];
        REG_DEADBAND: cfg.deadband        <= pwdata[DB_W-1:0];
        REG_POS_LIM:  cfg.pos_int_limit   <= pwdata[LIM_W-1:0];
        REG_NEG_LIM:  cfg.neg_int_limit   <= pwdata[LIM_W-1:0];
        REG_REVERSE:  cfg.reverse_output  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:       prdata = DATA_W'(cfg.kp);
      REG_KD:       prdata = DATA_W'(cfg.kd_over_period);
      REG_KI:       prdata = DATA_W'(cfg.ki_times_period);
      REG_DEADBAND: prdata = DATA_W'(cfg.deadband);
      REG_POS_LIM:  prdata = DATA_W'(cfg.pos_int_limit);
      REG_NEG_LIM:  prdata = DATA_W'(cfg.neg_int_limit);
      REG_REVERSE:  prdata = DATA_W'(cfg.reverse_output);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: design/fpdic_ctrl.sv
// sequencer that steps the datapath through one controller update
`timescale 1ns / 1ps

module fpdic_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  output logic                drive_valid,
  input  logic                drive_stall,
  output fpdic_pkg::dp_cmd_t  cmd
);
  import fpdic_pkg::*;

  ctrl_state_t state, state_next;
  logic        accept;
  logic        out_free;
  logic        out_load;

  assign accept   = sample_valid & ~sample_stall;
  assign out_free = ~drive_valid | ~drive_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_PREP;
      ST_PREP:  state_next = ST_RECIP;
      ST_RECIP: state_next = ST_QUOT;
      ST_QUOT:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_CORR;
      ST_CORR:  state_next = ST_KP;
      ST_KP:    state_next = ST_KD;
      ST_KD:    state_next = ST_DTERM;
      ST_DTERM: state_next = ST_AB;
      ST_AB:    state_next = ST_FUZZ;
      ST_FUZZ:  state_next = ST_KI;
      ST_KI:    state_next = ST_ACC;
      ST_ACC:   state_next = ST_DRV;
      ST_DRV:   state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = (state != ST_IDLE);
    out_load     = 1'b0;
    cmd.op       = OP_NONE;
    unique case (state)
      ST_IDLE:  if (sample_valid) cmd.op = OP_LOAD;
      ST_PREP:  cmd.op = OP_PREP;
      ST_RECIP: cmd.op = OP_RECIP;
      ST_QUOT:  cmd.op = OP_QUOT;
      ST_CHECK: cmd.op = OP_CHECK;
      ST_CORR:  cmd.op = OP_CORR;
      ST_KP:    cmd.op = OP_KP;
      ST_KD:    cmd.op = OP_KD;
      ST_DTERM: cmd.op = OP_DTERM;
      ST_AB:    cmd.op = OP_AB;
      ST_FUZZ:  cmd.op = OP_FUZZ;
      ST_KI:    cmd.op = OP_KI;
      ST_ACC:   cmd.op = OP_ACC;
      ST_DRV:   cmd.op = OP_DRV;
      ST_OUT: begin
        if (out_free) begin
          cmd.op   = OP_OUT;
          out_load = 1'b1;
        end
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (out_load) begin
      drive_valid <= 1'b1;
    end else if (~drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

endmodule

FILE: design/fpdic_datapath.sv
// error scaling, gain terms, fuzzy inference and integral over one shared multiplier
`timescale 1ns / 1ps

module fpdic_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpdic_pkg::dp_cmd_t                   cmd,
  input  fpdic_pkg::cfg_t                      cfg,
  input  logic signed [fpdic_pkg::IN_W-1:0]    setpoint,
  input  logic signed [fpdic_pkg::IN_W-1:0]    feedback,
  output logic signed [fpdic_pkg::OUT_W-1:0]   drive_out
);
  import fpdic_pkg::*;

  localparam int P_W   = FRAC_BITS + 2;
  localparam int A_W   = FRAC_BITS + 1;
  localparam int NUM_W = MAG_W + FRAC_BITS + 1;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [P_W-1:0] PONE = P_W'(ONE_L);

  function automatic logic signed [PROD_W-1:0] shr_trunc(
    input logic signed [PROD_W-1:0] v,
    input int                       sh
  );
    logic signed [PROD_W-1:0] bias;
    bias = v[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
    return (v + bias) >>> sh;
  endfunction

  function automatic logic signed [P_W-1:0] gain_clamp(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [PROD_W-1:0] t;
    t = shr_trunc(v, GAIN_SHIFT);
    if (t > ONE_L) begin
      return PONE;
    end else if (t < -ONE_L) begin
      return -PONE;
    end
    return P_W'(t);
  endfunction

  // held item and intermediate results
  logic signed [IN_W-1:0]   sp;
  logic signed [IN_W-1:0]   fb;
  logic [X_W-1:0]           num_x;
  logic                     sat;
  logic                     err_neg;
  logic                     inband;
  logic [Q_W-1:0]           quot;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [ERR_W:0]    err_delta;
  logic signed [P_W-1:0]    p_term;
  logic signed [P_W-1:0]    d_term;
  logic signed [P_W-1:0]    fuzzy;
  logic signed [LIM_W-1:0]  integral;
  logic signed [LIM_W-1:0]  integral_next;
  logic signed [OUT_W-1:0]  drive;
  logic signed [PROD_W-1:0] prod;

  // combinational helpers
  logic signed [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]         mag;
  logic [NUM_W-1:0]         num;
  logic [IN_W-1:0]          sp_mag;
  logic [X_W-1:0]           rem;
  logic [Q_W-1:0]           q_fix;
  logic [A_W-1:0]           p_abs;
  logic [A_W-1:0]           d_abs;
  logic [PROD_W-1:0]        w_fz;
  logic [P_W-1:0]           fz_mag;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [OUT_W-1:0]  drv;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;

  assign drive_out = drive;

  always_comb begin
    diff   = MAG_W'(sp) - MAG_W'(fb);
    mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    num    = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(ROUND_HALF);
    sp_mag = sp[IN_W-1] ? IN_W'(-sp) : IN_W'(sp);

    // quotient estimate is at most one low
    rem    = num_x - prod[X_W-1:0];
    q_fix  = (rem >= X_W'(DIV_CONST)) ? quot + Q_W'(1) : quot;

    p_abs  = p_term[P_W-1] ? A_W'(-p_term) : A_W'(p_term);
    d_abs  = d_term[P_W-1] ? A_W'(-d_term) : A_W'(d_term);
    // same-sign rules reduce to one*(|p|+|d|) - |p|*|d|
    w_fz   = ((PROD_W'(p_abs) + PROD_W'(d_abs)) << FRAC_BITS) - PROD_W'(prod);
    fz_mag = P_W'(w_fz >> FRAC_BITS);

    acc_sum = SUM_W'(integral) + SUM_W'(shr_trunc(prod, FRAC_BITS));
    if (inband) begin
      integral_next = '0;
    end else if (acc_sum > SUM_W'(cfg.pos_int_limit)) begin
      integral_next = cfg.pos_int_limit;
    end else if (acc_sum < SUM_W'(cfg.neg_int_limit)) begin
      integral_next = cfg.neg_int_limit;
    end else begin
      integral_next = LIM_W'(acc_sum);
    end

    // |integral*100/65536| stays far inside 16 bits
    drv = OUT_W'(shr_trunc(prod, DRV_SHIFT));
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      OP_RECIP: begin
        mul_a = MUL_W'(num_x);
        mul_b = MUL_W'(RECIP_MULT);
      end
      OP_CHECK: begin
        mul_a = MUL_W'(quot);
        mul_b = MUL_W'(DIV_CONST);
      end
      OP_KP: begin
        mul_a = MUL_W'(err);
        mul_b = MUL_W'(cfg.kp);
      end
      OP_KD: begin
        mul_a = MUL_W'(err_delta);
        mul_b = MUL_W'(cfg.kd_over_period);
      end
      OP_AB: begin
        mul_a = MUL_W'(p_abs);
        mul_b = MUL_W'(d_abs);
      end
      OP_KI: begin
        mul_a = MUL_W'(fuzzy);
        mul_b = MUL_W'(cfg.ki_times_period);
      end
      OP_DRV: begin
        mul_a = MUL_W'(integral);
        mul_b = MUL_W'(SCALE_OUT);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        sp <= setpoint;
        fb <= feedback;
      end
      OP_PREP: begin
        num_x   <= num[X_W-1:0];
        sat     <= (num >= NUM_W'(SAT_NUM));
        err_neg <= diff[MAG_W-1];
        inband  <= (sp_mag <= IN_W'(cfg.deadband));
      end
      OP_QUOT: quot <= prod[RECIP_SHIFT +: Q_W];
      OP_CORR: begin
        if (sat) begin
          err <= err_neg ? ERR_MIN : ERR_MAX;
        end else begin
          err <= err_neg ? -$signed(q_fix) : $signed(q_fix);
        end
      end
      OP_KP:    err_delta <= (ERR_W + 1)'(err) - (ERR_W + 1)'(last_err);
      OP_KD:    p_term <= gain_clamp(prod);
      OP_DTERM: d_term <= gain_clamp(prod);
      OP_FUZZ: begin
        if (p_term[P_W-1] != d_term[P_W-1]) begin
          fuzzy <= p_term + d_term;
        end else if (p_term[P_W-1]) begin
          fuzzy <= -$signed(fz_mag);
        end else begin
          fuzzy <= $signed(fz_mag);
        end
      end
      OP_OUT: drive <= cfg.reverse_output ? -drv : drv;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
      integral <= '0;
    end else begin
      if (cmd.op == OP_KP) begin
        last_err <= err;
      end
      if (cmd.op == OP_ACC) begin
        integral <= integral_next;
      end
    end
  end

endmodule

FILE: design/fuzzy_pd_integrating_controller_core.sv
// top level of the fuzzy pd-rule integrating controller
`timescale 1ns / 1ps

//  channel   handshake                    payload              width
//  sample    sample_valid / sample_stall  setpoint, feedback   16 s, 16 s
//  drive     drive_valid / drive_stall    drive_out            16 s
//  config    psel penable pwrite pready   paddr / pwdata       5 / 32
//
//  a new sample is accepted only while the sequencer is idle, once the result
//  of the previous item has been loaded into the output register
//  the steps run in order because one shared 32x32 multiplier forms seven
//  dependent products per item (reciprocal, check, kp, kd, rule, ki, scale)
//  a synchronous reset clears the sequencer, output valid, last error and
//  integral; configuration takes its documented reset values
//  a stalled drive result holds; the next sample is taken meanwhile and the
//  sequencer waits in its last step until the output register frees up

module fuzzy_pd_integrating_controller_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [fpdic_pkg::IN_W-1:0]    setpoint,
  input  logic signed [fpdic_pkg::IN_W-1:0]    feedback,
  // drive channel
  output logic                                 drive_valid,
  input  logic                                 drive_stall,
  output logic signed [fpdic_pkg::OUT_W-1:0]   drive_out,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fpdic_pkg::PADDR_W-1:0]        paddr,
  input  logic [fpdic_pkg::DATA_W-1:0]         pwdata,
  output logic [fpdic_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import fpdic_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  // gains, limits, deadband and output sense
  fpdic_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // step sequencer and handshakes
  fpdic_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .cmd          (cmd)
  );

  // arithmetic, last error, integral and output register
  fpdic_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .setpoint  (setpoint),
    .feedback  (feedback),
    .drive_out (drive_out)
  );

endmodule

FILE: test/tb_fuzzy_pd_integrating_controller_core.sv
// self-checking testbench of the fuzzy pd-rule integrating controller core
`timescale 1ns / 1ps

module tb_fuzzy_pd_integrating_controller_core;
  import fpdic_pkg::*;

  localparam int     FRAC          = 16;
  localparam longint UNIT          = 64'sd1 <<< FRAC;
  localparam longint ERR_SPAN      = 64'sd1 <<< (ERR_W - 1);
  localparam longint DRV_UNIT      = 64'sd1 <<< DRV_SHIFT;
  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     MAX_REPORTS   = 10;
  localparam int     RUN_ITEMS     = 94;
  // address just past the register list, must be ignored by the block
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [IN_W-1:0] sp;
    logic signed [IN_W-1:0] fb;
  } sample_t;

  // block ports
  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic signed [IN_W-1:0]    setpoint     = '0;
  logic signed [IN_W-1:0]    feedback     = '0;
  logic                      drive_valid;
  logic                      drive_stall  = 1'b0;
  logic signed [OUT_W-1:0]   drive_out;
  logic                      psel         = 1'b0;
  logic                      penable      = 1'b0;
  logic                      pwrite       = 1'b0;
  logic [PADDR_W-1:0]        paddr        = '0;
  logic [DATA_W-1:0]         pwdata       = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // stimulus and scoreboard
  sample_t                   pending[$];
  logic signed [OUT_W-1:0]   drive_expected[$];
  int unsigned               items_sent    = 0;
  int unsigned               items_taken   = 0;
  int unsigned               cycle_count   = 0;
  int                        error_count   = 0;
  int                        send_idle_pct = 0;
  int                        stall_pct     = 0;
  logic                      feed_hold     = 1'b0;

  // shadow of the controller registers and state
  cfg_t                      ctl_cfg;
  longint                    last_err_pu   = 0;
  longint                    integ_pu      = 0;

  fuzzy_pd_integrating_controller_core #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .setpoint     (setpoint),
    .feedback     (feedback),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .drive_out    (drive_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // triangular memberships of a term in [-1, +1]; the three always sum to one
  function automatic void split_member(input longint v, output longint neg_m,
                                       output longint zero_m, output longint pos_m);
    neg_m  = (v < 0) ? -v : 0;
    pos_m  = (v > 0) ? v : 0;
    zero_m = UNIT - ((v < 0) ? -v : v);
  endfunction

  // one control tick: error, p and d terms, rule inference, integral, drive
  task automatic predict_drive(input sample_t s);
    longint diff, mag, quo, err, p_term, d_term, sp_mag, acc, drv;
    longint pn, pz, pp, dn, dz, dp, wsum, fz;
    diff   = longint'(s.sp) - longint'(s.fb);
    mag    = (diff < 0) ? -diff : diff;
    // error in pu, rounded half away from zero, then saturated
    quo    = (mag * UNIT + ROUND_HALF) / DIV_CONST;
    if (quo > ERR_SPAN) quo = ERR_SPAN;
    err    = (diff < 0) ? -quo : quo;
    err    = clamp(err, -ERR_SPAN, ERR_SPAN - 1);
    p_term = clamp((err * longint'(ctl_cfg.kp)) / 256, -UNIT, UNIT);
    d_term = clamp(((err - last_err_pu) * longint'(ctl_cfg.kd_over_period)) / 256,
                   -UNIT, UNIT);
    sp_mag = (s.sp < 0) ? -longint'(s.sp) : longint'(s.sp);
    if (sp_mag > longint'(ctl_cfg.deadband)) begin
      split_member(p_term, pn, pz, pp);
      split_member(d_term, dn, dz, dp);
      wsum = (pp * dz + pz * dp + pp * dp) - (pn * dn + pz * dn + pn * dz);
      fz   = wsum / UNIT;
      acc  = integ_pu + (fz * longint'(ctl_cfg.ki_times_period)) / UNIT;
      // upper clamp wins when the limits cross
      if (acc > longint'($signed(ctl_cfg.pos_int_limit))) begin
        acc = longint'($signed(ctl_cfg.pos_int_limit));
      end else if (acc < longint'($signed(ctl_cfg.neg_int_limit))) begin
        acc = longint'($signed(ctl_cfg.neg_int_limit));
      end
      integ_pu = acc;
      drv = (acc * SCALE_OUT) / DRV_UNIT;
      if (ctl_cfg.reverse_output) drv = -drv;
      drv = clamp(drv, -32768, 32767);
    end else begin
      integ_pu = 0;
      drv      = 0;
    end
    last_err_pu = err;
    drive_expected.push_back(drv[OUT_W-1:0]);
  endtask

  // register write: setup cycle, access cycle, lands when pready is high
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KP:       ctl_cfg.kp              = value[KP_W-1:0];
      REG_KD:       ctl_cfg.kd_over_period  = value[KD_W-1:0];
      REG_KI:       ctl_cfg.ki_times_period = value[KI_W-1:0];
      REG_DEADBAND: ctl_cfg.deadband        = value[DB_W-1:0];
      REG_POS_LIM:  ctl_cfg.pos_int_limit   = value[LIM_W-1:0];
      REG_NEG_LIM:  ctl_cfg.neg_int_limit   = value[LIM_W-1:0];
      REG_REVERSE:  ctl_cfg.reverse_output  = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    pwdata  = $urandom();
  endtask

  // all registers, with junk above each field's width
  task automatic apply_settings(input cfg_t want);
    logic [DATA_W-1:0] noise;
    noise = $urandom();
    write_reg(REG_KP, {noise[31:16], want.kp});
    noise = $urandom();
    write_reg(REG_KD, {noise[31:24], want.kd_over_period});
    noise = $urandom();
    write_reg(REG_KI, {noise[31:16], want.ki_times_period});
    noise = $urandom();
    write_reg(REG_DEADBAND, {noise[31:15], want.deadband});
    noise = $urandom();
    write_reg(REG_POS_LIM, {noise[31:21], want.pos_int_limit});
    noise = $urandom();
    write_reg(REG_NEG_LIM, {noise[31:21], want.neg_int_limit});
    noise = $urandom();
    write_reg(REG_REVERSE, {noise[31:1], want.reverse_output});
  endtask

  function automatic cfg_t make_settings(input int kp, input int kd, input int ki,
                                         input int db, input int pos_lim,
                                         input int neg_lim, input bit rev);
    cfg_t c;
    c.kp              = KP_W'(kp);
    c.kd_over_period  = KD_W'(kd);
    c.ki_times_period = KI_W'(ki);
    c.deadband        = DB_W'(db);
    c.pos_int_limit   = LIM_W'(pos_lim);
    c.neg_int_limit   = LIM_W'(neg_lim);
    c.reverse_output  = rev;
    return c;
  endfunction

  // mostly workable gains and limits, each field now and then at an extreme
  function automatic cfg_t random_settings();
    cfg_t c;
    c.kp = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                    : KP_W'($urandom_range(0, 1024));
    c.kd_over_period = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 24'hFFFFFF : 24'h0)
                                                : KD_W'($urandom_range(0, 2048));
    if ($urandom_range(7) == 0) c.kd_over_period = KD_W'($urandom());
    c.ki_times_period = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                                 : KI_W'($urandom());
    c.deadband = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 15'h7FFF : 15'h0)
               : ($urandom_range(9) == 0) ? DB_W'($urandom())
                                          : DB_W'($urandom_range(0, 300));
    case ($urandom_range(7))
      0:       c.pos_int_limit = 21'h0FFFFF;
      1:       c.pos_int_limit = 21'h100000;
      2, 3:    c.pos_int_limit = LIM_W'($urandom_range(0, 150000));
      default: c.pos_int_limit = LIM_W'($urandom_range(0, 1048575));
    endcase
    case ($urandom_range(7))
      0:       c.neg_int_limit = 21'h100000;
      1:       c.neg_int_limit = 21'h0FFFFF;
      2, 3:    c.neg_int_limit = LIM_W'(-int'($urandom_range(0, 150000)));
      default: c.neg_int_limit = LIM_W'(-int'($urandom_range(0, 1048576)));
    endcase
    c.reverse_output = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic void add_sample(input int sp, input int fb);
    sample_t s;
    s.sp = IN_W'(sp);
    s.fb = IN_W'(fb);
    pending.push_back(s);
  endfunction

  // setpoint steps held for a few ticks while feedback closes in, plus noise
  task automatic queue_run(input int count);
    sample_t s;
    logic signed [IN_W-1:0] wide;
    int target, level, left;
    left = 0;
    target = 0;
    level = 0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        left = $urandom_range(1, 12);
        wide = IN_W'($urandom());
        target = ($urandom_range(4) == 0) ? int'(wide) : int'($urandom_range(0, 1600)) - 800;
        level = target + int'($urandom_range(0, 400)) - 200;
      end
      left--;
      case ($urandom_range(9))
        0: begin
          s.sp = IN_W'($urandom());
          s.fb = IN_W'($urandom());
        end
        1: begin
          s.sp = IN_W'(target);
          s.fb = IN_W'($urandom());
        end
        default: begin
          level = level + (target - level) / 4 + int'($urandom_range(0, 10)) - 5;
          s.sp = IN_W'(target);
          s.fb = IN_W'(level);
        end
      endcase
      pending.push_back(s);
    end
  endtask

  // every issued item accepted and every result back
  task automatic wait_results();
    do @(negedge clk);
    while (items_sent != items_taken || drive_expected.size() != 0);
  endtask

  // empty the stimulus queue, then leave the sequencer time to go idle
  task automatic drain_all();
    while (pending.size() != 0) @(negedge clk);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: next item goes out once the current one is taken
  always @(negedge clk) begin : feeder
    sample_t s;
    if (rst) begin
      sample_valid <= 1'b0;
      drive_stall  <= 1'b0;
    end else begin
      if (!sample_valid || items_taken == items_sent) begin
        if (!feed_hold && pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s = pending.pop_front();
          setpoint     <= s.sp;
          feedback     <= s.fb;
          sample_valid <= 1'b1;
          items_sent   <= items_sent + 1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
      // receiver backpressure
      drive_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on each accepted sample, check each accepted drive item
  always @(posedge clk) begin : monitor
    logic signed [OUT_W-1:0] want;
    sample_t                 seen;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        items_taken <= items_taken + 1;
        seen.sp = setpoint;
        seen.fb = feedback;
        predict_drive(seen);
      end
      if (drive_valid && !drive_stall) begin
        if (drive_expected.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected drive item: got %0d", drive_out);
          end
        end else begin
          want = drive_expected.pop_front();
          if (drive_out !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("drive_out mismatch: expected %0d got %0d", want, drive_out);
            end
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_fuzzy_pd_integrating_controller_core failed");
    $finish;
  end

  initial begin
    ctl_cfg = make_settings(int'(KP_RESET), 0, 0, 0, int'(POS_LIM_RESET),
                            int'(NEG_LIM_RESET), 1'b0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 11;
    stall_pct     = 86;

    // reset settings: unit kp, no d and no integral gain
    add_sample(0, 0);
    add_sample(32767, -32768);
    add_sample(-300, 100);
    drain_all();

    // moderate gains, small deadband: deadband edges and error saturation
    apply_settings(make_settings(256, 256, 65535, 20, 196608, -196608, 1'b0));
    feed_hold = 1'b1;
    add_sample(0, 0);
    add_sample(20, 0);
    add_sample(21, 0);
    add_sample(-20, 5);
    add_sample(-21, 5);
    add_sample(400, 0);
    add_sample(400, 300);
    add_sample(32767, -32768);
    add_sample(-32768, 32767);
    add_sample(100, 100);
    feed_hold = 1'b0;
    // hold the sender off until the pipeline has emptied
    while (pending.size() > 5) @(negedge clk);
    feed_hold = 1'b1;
    wait_results();
    feed_hold = 1'b0;
    drain_all();

    // largest gains, widest deadband and limits, reversed drive
    apply_settings(make_settings(65535, 24'hFFFFFF, 65535, 32767, 1048575, -1048576, 1'b1));
    add_sample(32767, 0);
    add_sample(-32768, 0);
    add_sample(-32768, 32767);
    add_sample(-32768, -32768);
    drain_all();

    // zero gains, crossed limits, and a write past the register list
    apply_settings(make_settings(0, 0, 0, 0, -1048576, 1048575, 1'b0));
    write_reg(REG_NONE, $urandom());
    add_sample(1, 0);
    add_sample(0, 0);
    add_sample(5, -5);
    drain_all();

    // random part, three backpressure profiles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 11;
          stall_pct     = 86;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 11;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        apply_settings(random_settings());
        queue_run(RUN_ITEMS);
        if (blk == 2) begin
          // mid-run pause until every result is home
          while (pending.size() > RUN_ITEMS / 2) @(negedge clk);
          feed_hold = 1'b1;
          wait_results();
          feed_hold = 1'b0;
        end
        drain_all();
      end
    end

    if (error_count == 0 && drive_expected.size() == 0) begin
      $display("tb_fuzzy_pd_integrating_controller_core passed");
    end else begin
      $display("tb_fuzzy_pd_integrating_controller_core failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/fpdic_pkg.sv
design/fpdic_cfg_regs.sv
design/fpdic_ctrl.sv
design/fpdic_datapath.sv
design/fuzzy_pd_integrating_controller_core.sv
test/tb_fuzzy_pd_integrating_controller_core.sv
